### rtl/core/tfa_pkg.sv
// tfa_pkg: payload types and allocation coefficients for the force allocation block.
// No dependencies.
package tfa_pkg;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_pitch;
        logic signed [31:0] torque_roll;
        logic signed [31:0] torque_yaw;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] thrust_1;
        logic signed [31:0] thrust_2;
        logic signed [31:0] thrust_3;
        logic signed [31:0] thrust_4;
        logic signed [31:0] thrust_5;
        logic signed [31:0] thrust_6;
    } t_out_word;

    localparam int NORM_Q = 30;
    localparam int ACC_Q  = 60;

    // Q30 coefficients of the inverse allocation matrix
    localparam logic signed [31:0] K_X = 32'sd295730081;
    localparam logic signed [31:0] K_Y = 32'sd1103417350;
    localparam logic signed [31:0] K_P = 32'sd609581978;
    localparam logic signed [31:0] K_W = 32'sd385058746;
    localparam logic signed [31:0] K_V = 32'sd153081160;
    localparam logic signed [31:0] K_H = 32'sd536870912;
    localparam logic signed [31:0] K_R = 32'sd766958446;
    localparam logic signed [31:0] K_U = 32'sd88843211;

    // row = thruster, col = x, y, z, pitch, roll, yaw
    function automatic logic signed [31:0] coef(input logic [2:0] row, input logic [2:0] col);
        logic signed [31:0] k;
        k = '0;
        case (col)
            3'd0: k = (row < 3'd2) ? K_X : (row < 3'd4) ? -K_X : K_V;
            3'd1: begin
                case (row)
                    3'd0, 3'd2: k = -K_Y;
                    3'd1, 3'd3: k = K_Y;
                    default:    k = '0;
                endcase
            end
            3'd2: k = (row >= 3'd4) ? -K_H : 32'sd0;
            3'd3: k = (row < 3'd4) ? K_P : 32'sd0;
            3'd4: begin
                case (row)
                    3'd4:    k = -K_R;
                    3'd5:    k = K_R;
                    default: k = '0;
                endcase
            end
            3'd5: begin
                case (row)
                    3'd0, 3'd3, 3'd5: k = -K_W;
                    3'd1, 3'd2:       k = K_W;
                    3'd4:             k = K_U;
                    default:          k = '0;
                endcase
            end
            default: k = '0;
        endcase
        if (row == 3'd5 && col == 3'd5) k = -K_U;
        return k;
    endfunction

endpackage

### rtl/core/tfa_isqrt.sv
// tfa_isqrt: pipelined floor square root of a 66-bit value, one root bit per stage,
// with a sideband payload that travels alongside. Depends on nothing.
module tfa_isqrt #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [65:0]       i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [32:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int NS = 33;

    logic [NS:0]       r_v;
    logic [65:0]       r_rad  [NS+1];
    logic [34:0]       r_rem  [NS+1];
    logic [32:0]       r_root [NS+1];
    logic [SIDE_W-1:0] r_side [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [34:0] n_rem;
        logic [34:0] n_trial;
        logic [32:0] n_root;
        always_comb begin
            n_rem   = {r_rem[s][32:0], r_rad[s][65:64]};
            n_trial = {r_root[s][32:0], 2'b01};
            if (n_rem >= n_trial) begin
                n_rem  = n_rem - n_trial;
                n_root = {r_root[s][31:0], 1'b1};
            end else begin
                n_root = {r_root[s][31:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s+1]  <= {r_rad[s][63:0], 2'b00};
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_root  = r_root[NS];
    assign o_side  = r_side[NS];
endmodule

### rtl/core/tfa_div.sv
// tfa_div: pipelined restoring divider, q = num / den for a 63-bit numerator
// and 34-bit divisor, one quotient bit per stage. Depends on nothing.
module tfa_div #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [62:0]       i_num,
    input  logic [33:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo,
    output logic [SIDE_W-1:0] o_side
);
    // quotient stays below 2^31+1, so 32 quotient bits cover it
    localparam int NS = 32;

    logic [NS:0]       r_v;
    logic [62:0]       r_num  [NS+1];
    logic [33:0]       r_den  [NS+1];
    logic [34:0]       r_rem  [NS+1];
    logic [31:0]       r_quo  [NS+1];
    logic [SIDE_W-1:0] r_side [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // top 31 bits of numerator are below den (num < 2^32 * den)
            r_rem[0]  <= {4'd0, i_num[62:32]};
            r_num[0]  <= {i_num[31:0], 31'd0};
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [35:0] n_sh;
        logic [34:0] n_rem;
        logic        n_bit;
        always_comb begin
            n_sh  = {r_rem[s], r_num[s][62]};
            n_bit = (n_sh >= {2'b00, r_den[s]});
            n_rem = n_bit ? 35'(n_sh - {2'b00, r_den[s]}) : n_sh[34:0];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_num[s+1]  <= {r_num[s][61:0], 1'b0};
                r_den[s+1]  <= r_den[s];
                r_quo[s+1]  <= {r_quo[s][30:0], n_bit};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_quo   = r_quo[NS];
    assign o_side  = r_side[NS];
endmodule

### rtl/core/thruster_force_allocation.sv
// thruster_force_allocation: top level, wrench normalization and inverse allocation.
// Depends on tfa_pkg, tfa_isqrt and tfa_div.
//
// Usage:
//   Input channel i_valid/o_ready carries one wrench word (six Q16.16 values).
//   Output channel o_valid/i_ready carries one word of six thruster commands
//   with FRAC_BITS fraction bits, saturated to 32 bits.
//   The wrench is scaled to unit Euclidean length (all-zero passes as zero),
//   then multiplied by the fixed inverse allocation matrix.
//   Throughput: one word per cycle while the receiver does not stall. The path is
//   75 register stages: 34 in the square-root pipeline, 33 in the dividers
//   (each an input register plus one stage per result bit) and 8 for magnitudes,
//   squaring, summing, sign, multiply, row-sum and rounding.
//   The whole pipeline advances only when its last stage is empty or the
//   receiver takes the word; a stall freezes everything, nothing is lost.
//   o_ready = !o_valid || i_ready, so a new word enters in the same cycle
//   the old one is taken.
//   Reset (i_rst_n low, synchronous) clears all valid bits; data regs are not reset.
module thruster_force_allocation #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tfa_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output tfa_pkg::t_out_word o_data
);
    localparam int SH = tfa_pkg::ACC_Q - FRAC_BITS;

    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // stage A: magnitudes and signs
    logic [31:0] r_a_mag [6];
    logic [5:0]  r_a_neg;
    logic        r_a_v;
    logic signed [31:0] w_in [6];
    assign w_in[0] = i_data.force_x;
    assign w_in[1] = i_data.force_y;
    assign w_in[2] = i_data.force_z;
    assign w_in[3] = i_data.torque_pitch;
    assign w_in[4] = i_data.torque_roll;
    assign w_in[5] = i_data.torque_yaw;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r_a_neg[i] <= w_in[i][31];
                r_a_mag[i] <= w_in[i][31] ? 32'(-w_in[i]) : w_in[i];
            end
        end
    end

    // stage B: squares
    logic [63:0] r_b_sq [6];
    logic [31:0] r_b_mag [6];
    logic [5:0]  r_b_neg;
    logic        r_b_v;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r_b_sq[i]  <= r_a_mag[i] * r_a_mag[i];
                r_b_mag[i] <= r_a_mag[i];
            end
            r_b_neg <= r_a_neg;
        end
    end

    // stage C: pair sums; stage D: total
    logic [64:0] r_c_ps [3];
    logic [31:0] r_c_mag [6];
    logic [5:0]  r_c_neg;
    logic        r_c_v;
    logic [65:0] r_d_sum;
    logic [31:0] r_d_mag [6];
    logic [5:0]  r_d_neg;
    logic        r_d_v;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_c_ps[i] <= {1'b0, r_b_sq[2*i]} + {1'b0, r_b_sq[2*i+1]};
            end
            r_c_mag <= r_b_mag;
            r_c_neg <= r_b_neg;
            r_d_sum <= {1'b0, r_c_ps[0]} + {1'b0, r_c_ps[1]} + {1'b0, r_c_ps[2]};
            r_d_mag <= r_c_mag;
            r_d_neg <= r_c_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    // square root, magnitudes and signs ride along
    localparam int SQ_SIDE = 6 * 32 + 6;
    logic [SQ_SIDE-1:0] w_sq_side_in, w_sq_side_out;
    logic               w_sq_v;
    logic [32:0]        w_root;
    always_comb begin
        for (int i = 0; i < 6; i++) w_sq_side_in[i*32 +: 32] = r_d_mag[i];
        w_sq_side_in[SQ_SIDE-1 -: 6] = r_d_neg;
    end

    tfa_isqrt #(.SIDE_W(SQ_SIDE)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_rad   (r_d_sum),
        .i_side  (w_sq_side_in),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side_out)
    );

    // six dividers: q = (mag << 31 + m) / (2m); zero root means zero vector
    logic [33:0] w_den;
    logic        w_zero;
    assign w_zero = (w_root == '0);
    assign w_den  = w_zero ? 34'd1 : {w_root, 1'b0};

    logic [31:0] w_quo [6];
    logic        w_dv [6];
    logic        w_dneg [6];
    for (genvar i = 0; i < 6; i++) begin : g_div
        logic [62:0] w_num;
        assign w_num = w_zero ? 63'd0
                     : 63'({w_sq_side_out[i*32 +: 32], 31'd0}) + 63'(w_root);
        tfa_div #(.SIDE_W(1)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v),
            .i_num   (w_num),
            .i_den   (w_den),
            .i_side  (w_sq_side_out[SQ_SIDE-6 + i]),
            .o_valid (w_dv[i]),
            .o_quo   (w_quo[i]),
            .o_side  (w_dneg[i])
        );
    end

    // stage E: signed normalized Q30 values
    logic signed [31:0] r_e_n [6];
    logic               r_e_v;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r_e_n[i] <= w_dneg[i] ? -$signed(w_quo[i]) : $signed(w_quo[i]);
            end
        end
    end

    // stage F: 36 products; stage G: row sums
    logic signed [63:0] r_f_p [6][6];
    logic               r_f_v;
    logic signed [66:0] r_g_acc [6];
    logic               r_g_v;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                for (int i = 0; i < 6; i++) begin
                    r_f_p[j][i] <= tfa_pkg::coef(3'(j), 3'(i)) * r_e_n[i];
                end
            end
            for (int j = 0; j < 6; j++) begin
                r_g_acc[j] <= 67'(r_f_p[j][0]) + 67'(r_f_p[j][1]) + 67'(r_f_p[j][2])
                            + 67'(r_f_p[j][3]) + 67'(r_f_p[j][4]) + 67'(r_f_p[j][5]);
            end
        end
    end

    // stage H: round half away from zero, saturate
    logic signed [31:0] r_h_t [6];
    logic               r_h_v;
    always_ff @(posedge i_clk) begin
        logic [66:0] amag;
        logic [66:0] rr;
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                amag = r_g_acc[j][66] ? 67'(-r_g_acc[j]) : 67'(r_g_acc[j]);
                rr   = (amag + (67'd1 << (SH - 1))) >> SH;
                if (r_g_acc[j][66]) begin
                    r_h_t[j] <= (rr > 67'h80000000) ? 32'sh80000000 : 32'(-rr);
                end else begin
                    r_h_t[j] <= (rr > 67'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(rr);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= w_dv[0];
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    assign o_valid         = r_h_v;
    assign o_data.thrust_1 = r_h_t[0];
    assign o_data.thrust_2 = r_h_t[1];
    assign o_data.thrust_3 = r_h_t[2];
    assign o_data.thrust_4 = r_h_t[3];
    assign o_data.thrust_5 = r_h_t[4];
    assign o_data.thrust_6 = r_h_t[5];
endmodule

### bench/tfa_checker.sv
// tfa_checker: watches both channels of thruster_force_allocation, predicts each
// thruster word from the accepted wrench and compares. Depends on tfa_pkg.
`timescale 1ns / 1ps
module tfa_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  tfa_pkg::t_in_word  i_wrench,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tfa_pkg::t_out_word i_thrust,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_words_seen
);
    tfa_pkg::t_out_word thrust_q[$];

    function automatic logic signed [63:0] k_of(input int r, input int c);
        logic signed [63:0] t[6][6];
        t = '{'{tfa_pkg::K_X, -tfa_pkg::K_Y, 0, tfa_pkg::K_P, 0, -tfa_pkg::K_W},
              '{tfa_pkg::K_X, tfa_pkg::K_Y, 0, tfa_pkg::K_P, 0, tfa_pkg::K_W},
              '{-tfa_pkg::K_X, -tfa_pkg::K_Y, 0, tfa_pkg::K_P, 0, tfa_pkg::K_W},
              '{-tfa_pkg::K_X, tfa_pkg::K_Y, 0, tfa_pkg::K_P, 0, -tfa_pkg::K_W},
              '{tfa_pkg::K_V, 0, -tfa_pkg::K_H, 0, -tfa_pkg::K_R, tfa_pkg::K_U},
              '{tfa_pkg::K_V, 0, -tfa_pkg::K_H, 0, tfa_pkg::K_R, -tfa_pkg::K_U}};
        return t[r][c];
    endfunction

    function automatic logic [63:0] root_floor(input logic [65:0] s);
        logic [63:0] r;
        logic [65:0] sq;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            sq = ({2'b0, r} | (66'd1 << b)) * ({2'b0, r} | (66'd1 << b));
            if (b < 33 && sq <= s) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic tfa_pkg::t_out_word allocate(input tfa_pkg::t_in_word w);
        logic signed [63:0] v[6];
        logic [63:0] mg[6];
        logic signed [63:0] nrm[6];
        logic [65:0] sum;
        logic [63:0] m, q, amag, rnd;
        logic signed [63:0] acc;
        logic signed [31:0] res[6];
        int sh;
        tfa_pkg::t_out_word o;
        sh = 60 - FRAC_BITS;
        v = '{w.force_x, w.force_y, w.force_z, w.torque_pitch, w.torque_roll,
              w.torque_yaw};
        sum = '0;
        for (int i = 0; i < 6; i++) begin
            mg[i] = v[i] < 0 ? -v[i] : v[i];
            sum += mg[i] * mg[i];
        end
        if (sum == 0) return '0;
        m = root_floor(sum);
        for (int i = 0; i < 6; i++) begin
            q = ((mg[i] << (tfa_pkg::NORM_Q + 1)) + m) / (m << 1);
            nrm[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        for (int j = 0; j < 6; j++) begin
            acc = 0;
            for (int i = 0; i < 6; i++) acc += k_of(j, i) * nrm[i];
            amag = acc < 0 ? -acc : acc;
            rnd = (amag + (64'd1 << (sh - 1))) >> sh;
            if (acc < 0) res[j] = rnd > 64'h8000_0000 ? 32'sh8000_0000 : -rnd[31:0];
            else res[j] = rnd > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : rnd[31:0];
        end
        o.thrust_1 = res[0]; o.thrust_2 = res[1]; o.thrust_3 = res[2];
        o.thrust_4 = res[3]; o.thrust_5 = res[4]; o.thrust_6 = res[5];
        return o;
    endfunction

    assign o_pending = thrust_q.size();

    always @(posedge i_clk) begin
        tfa_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_words_seen <= 0;
        end else begin
            if (i_valid && i_ready_in) thrust_q.push_back(allocate(i_wrench));
            if (i_out_valid && i_out_ready) begin
                o_words_seen <= o_words_seen + 1;
                if (thrust_q.size() == 0) begin
                    if (o_fail_count < 10) $display("ERROR: unexpected word %h", i_thrust);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = thrust_q.pop_front();
                    if (exp_w !== i_thrust) begin
                        if (o_fail_count < 10)
                            $display("ERROR: thrust mismatch exp %h got %h", exp_w, i_thrust);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### bench/tb_thruster_force_allocation.sv
// tb_thruster_force_allocation: stimulus and verdict for the force allocation block.
// Depends on tfa_pkg, thruster_force_allocation and tfa_checker.
`timescale 1ns / 1ps
module tb_thruster_force_allocation;
    logic               clk, rst_n;
    logic               in_valid, in_ready, out_valid, out_ready;
    tfa_pkg::t_in_word  in_word;
    tfa_pkg::t_out_word out_word;
    int                 fails, pending, seen;
    int                 n_sent;

    thruster_force_allocation i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_data(in_word), .o_valid(out_valid), .i_ready(out_ready), .o_data(out_word)
    );

    tfa_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_wrench(in_word), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_thrust(out_word), .o_fail_count(fails), .o_pending(pending),
        .o_words_seen(seen)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // random component: full range, near extremes, small, or zero
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 255) - 128;
            3: return 0;
            default: return $urandom();
        endcase
    endfunction

    // sink stalls: ready held low for a random gap before each word, with quiet stretches
    initial begin
        int gap;
        out_ready = 0;
        @(posedge clk iff rst_n);
        forever begin
            gap = (seen / 100) % 3 == 2 ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                out_ready <= 0;
                @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk iff out_valid);
        end
    end

    task automatic send_word(input tfa_pkg::t_in_word w);
        int gap;
        gap = (n_sent / 100) % 3 == 1 ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_word  <= w;
        @(posedge clk iff in_ready);
        n_sent++;
    endtask

    initial begin
        tfa_pkg::t_in_word w;
        int drain;
        in_valid = 0;
        in_word  = '0;
        rst_n    = 0;
        n_sent   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero wrench, single-axis extremes and ones, all extremes, all minus one, mixed signs
        send_word('0);
        for (int a = 0; a < 6; a++) begin
            w = '0;
            w[191 - 32*a -: 32] = 32'h8000_0000;
            send_word(w);
            w[191 - 32*a -: 32] = 32'h7FFF_FFFF;
            send_word(w);
            w[191 - 32*a -: 32] = 32'h0000_0001;
            send_word(w);
        end
        send_word({6{32'h7FFF_FFFF}});
        send_word({6{32'h8000_0000}});
        send_word({6{32'hFFFF_FFFF}});
        send_word({3{32'h8000_0000, 32'h7FFF_FFFF}});

        for (int n = 0; n < 930; n++) begin
            for (int a = 0; a < 6; a++) w[191 - 32*a -: 32] = rand_comp();
            send_word(w);
        end
        in_valid <= 0;

        drain = 0;
        while (pending != 0 && drain < 100000) begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);
        $display("Covered %0d wrench words, %0d thruster words checked.", n_sent, seen);
        if (fails == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
